@@ rtl/core/grc_pkg.sv @@
// Shared types and constants of the grid ray caster.
package grc_pkg;

  // Shared restoring divider: quotient and divisor widths
  localparam int DivNumW = 33;
  localparam int DivDenW = 24;

  // Signed map coordinate width: a cell index plus room for one step outside
  localparam int MapCoordW = 9;

  // Side distance accumulator width, unsigned Q26.16
  localparam int SideW = 42;

  // Register index decoded from paddr[2]
  localparam logic RegScreenHeight = 1'b0;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/grc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module grc_div import grc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivNumW + 1);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDenW:0]   rem_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] den_q;

  logic [DivDenW:0] trial, diff;
  logic             fits;

  assign trial = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the partial remainder, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff : trial;
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ rtl/core/grid_ray_cast_wall_column.sv @@
// Top level of the grid ray caster: tile map, DDA walk sequencer and result stage.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | action, cell, tile_value, origin, ray_dir
//  out     | output    | out_valid_o / out_stall_i  | distance, side, hit cell, tex, line, span
//  cfg     | input     | psel/penable/pwrite/pready | screen_height at byte address 0
//
// A tile write is taken in the idle state. A cast runs two reciprocal divisions, the multiply
// states MULX, MULY and SIDEY, a grid step per cell (step, then registered map read; the
// step that leaves the map skips the read), a line height division and the result states
// TEX and DONE. Most of a cast is spent in the shared divider. After reset a clearing pass
// writes zero to all MAP_DIM*MAP_DIM tiles, one per cycle, with the input stalled. A
// finished result waits in the output register while the next items are taken.
module grid_ray_cast_wall_column import grc_pkg::*; #(
  parameter int MAP_DIM  = 128,
  parameter int TEX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transfer
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [6:0]  cell_x_i,
  input  logic [6:0]  cell_y_i,
  input  logic [7:0]  tile_value_i,
  input  logic [22:0] origin_x_i,
  input  logic [22:0] origin_y_i,
  input  logic signed [18:0] ray_dir_x_i,
  input  logic signed [18:0] ray_dir_y_i,
  // output transfer
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] perp_distance_o,
  output logic        hit_side_o,
  output logic [6:0]  hit_x_o,
  output logic [6:0]  hit_y_o,
  output logic        left_map_o,
  output logic [5:0]  tex_column_o,
  output logic [15:0] line_height_o,
  output logic [11:0] draw_start_o,
  output logic [11:0] draw_end_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CellW = $clog2(MAP_DIM);
  localparam int Depth = MAP_DIM * MAP_DIM;
  localparam int AddrW = $clog2(Depth);
  localparam int TexW  = $clog2(TEX_SIZE + 1);
  localparam int TexPW = 32 + TexW;
  localparam logic [AddrW-1:0]     MapDimA = AddrW'(MAP_DIM);
  localparam logic [MapCoordW-1:0] MapDimC = MapCoordW'(MAP_DIM);
  localparam logic [AddrW-1:0]     LastA   = AddrW'(Depth - 1);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RECX  = 13'b0000000000100,
    S_RECY  = 13'b0000000001000,
    S_MULX  = 13'b0000000010000,
    S_MULY  = 13'b0000000100000,
    S_SIDEY = 13'b0000001000000,
    S_STEP  = 13'b0000010000000,
    S_TEST  = 13'b0000100000000,
    S_DIST  = 13'b0001000000000,
    S_LINE  = 13'b0010000000000,
    S_TEX   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------- configuration
  logic [11:0] height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegScreenHeight);
  assign prdata = (paddr[2] == RegScreenHeight) ? {20'b0, height_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 12'd480;
    end else if (cfg_wr) begin
      height_q <= pwdata[11:0];
    end
  end

  // ---------------------------------------------------------------- tile map
  logic [7:0]       tile_mem [Depth];
  logic [7:0]       rd_tile_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [7:0]       mem_wd;
  logic [AddrW-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tile_mem[mem_wa] <= mem_wd;
    end
    rd_tile_q <= tile_mem[mem_ra];
  end

  // ---------------------------------------------------------------- item registers
  logic                       in_acc, cast_acc, wr_acc, wr_in_map;
  logic [15:0]                fx_q, fy_q;
  logic signed [18:0]         dir_x_q, dir_y_q;
  logic                       neg_x, neg_y;
  logic [MapCoordW-1:0]       mx_q, my_q, nx, ny, mx_d, my_d;
  logic [31:0]                rec_x_q, rec_y_q, rec_x_d, rec_y_d;
  logic [SideW-1:0]           side_x_q, side_y_q, side_x_d, side_y_d;
  logic                       side_q, side_d, left_q, left_d;
  logic [23:0]                perp_q, perp_d;
  logic [SideW-1:0]           perp_full;
  logic [15:0]                line_q, line_d;
  logic [5:0]                 tex_q, tex_d;
  logic                       in_map;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign cast_acc  = in_acc && action_i;
  assign wr_acc    = in_acc && !action_i;
  assign wr_in_map = ({1'b0, cell_x_i} < 8'(MAP_DIM)) && ({1'b0, cell_y_i} < 8'(MAP_DIM));
  assign in_stall_o = (state_q != S_IDLE);

  assign neg_x = dir_x_q[18];
  assign neg_y = dir_y_q[18];

  // ---------------------------------------------------------------- shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [19:0] mag_x, mag_y;

  assign mag_x = ray_dir_x_i[18] ? -{ray_dir_x_i[18], ray_dir_x_i} : {1'b0, ray_dir_x_i};
  assign mag_y = dir_y_q[18] ? -{dir_y_q[18], dir_y_q} : {1'b0, dir_y_q};

  grc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // ---------------------------------------------------------------- shared multiplier
  logic [31:0]        mul_a;
  logic signed [19:0] mul_b;
  logic signed [52:0] mul_q;
  logic [16:0]        frac_x, frac_y;

  assign frac_x = neg_x ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
  assign frac_y = neg_y ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};

  always_comb begin
    mul_a = 32'b0;
    mul_b = 20'sb0;
    case (state_q)
      S_MULX: begin
        mul_a = rec_x_q;
        mul_b = $signed({3'b0, frac_x});
      end
      S_MULY: begin
        mul_a = rec_y_q;
        mul_b = $signed({3'b0, frac_y});
      end
      S_LINE: begin
        mul_a = {8'b0, perp_q};
        mul_b = side_q ? 20'(dir_x_q) : 20'(dir_y_q);
      end
      default: begin
        mul_a = 32'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= $signed({1'b0, mul_a}) * mul_b;
  end

  // ---------------------------------------------------------------- DDA step
  logic x_first;

  assign x_first = side_x_q < side_y_q;
  assign nx = x_first ? mx_q + (neg_x ? '1 : MapCoordW'(1)) : mx_q;
  assign ny = x_first ? my_q : my_q + (neg_y ? '1 : MapCoordW'(1));
  assign in_map = !nx[MapCoordW-1] && (nx < MapDimC) && !ny[MapCoordW-1] && (ny < MapDimC);

  assign perp_full = side_q ? side_y_q - SideW'(rec_y_q) : side_x_q - SideW'(rec_x_q);
  assign perp_d    = (|perp_full[SideW-1:24]) ? 24'hFFFFFF : perp_full[23:0];

  // ---------------------------------------------------------------- texture column
  logic [31:0]       tex_frac;
  logic [TexPW-1:0]  tex_prod;
  logic [TexW-1:0]   texc, texf;
  logic              flip;

  assign tex_frac = {(side_q ? fx_q : fy_q), 16'b0} + mul_q[31:0];
  assign tex_prod = TexPW'(tex_frac) * TexPW'(TEX_SIZE);
  assign texc     = tex_prod[TexPW-1:32];
  assign flip     = (!side_q && !neg_x && (dir_x_q != '0)) || (side_q && neg_y);
  assign texf     = flip ? TexW'(TEX_SIZE - 1) - texc : texc;
  assign tex_d    = 6'(texf);

  // ---------------------------------------------------------------- drawing span
  logic signed [16:0] ds_full;
  logic [15:0]        de_full;
  logic [11:0]        draw_s, draw_e;

  assign ds_full = $signed({6'b0, height_q[11:1]}) - $signed({2'b0, line_q[15:1]});
  assign de_full = {1'b0, line_q[15:1]} + {5'b0, height_q[11:1]};
  assign draw_s  = ds_full[16] ? 12'd0 : ds_full[11:0];
  assign draw_e  = (height_q == 12'd0) ? 12'd0 :
                   (de_full > {4'b0, height_q - 12'd1}) ? height_q - 12'd1 : de_full[11:0];

  // ---------------------------------------------------------------- sequencer
  logic load_out;

  always_comb begin
    state_d   = state_q;
    rec_x_d   = rec_x_q;
    rec_y_d   = rec_y_q;
    side_x_d  = side_x_q;
    side_y_d  = side_y_q;
    mx_d      = mx_q;
    my_d      = my_q;
    side_d    = side_q;
    left_d    = left_q;
    line_d    = line_q;
    load_out  = 1'b0;
    div_req   = '0;
    mem_we    = 1'b0;
    mem_wa    = AddrW'(cell_x_i[CellW-1:0]) * MapDimA + AddrW'(cell_y_i[CellW-1:0]);
    mem_wd    = tile_value_i;
    mem_ra    = AddrW'(nx[CellW-1:0]) * MapDimA + AddrW'(ny[CellW-1:0]);
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 8'd0;
        if (clr_q == LastA) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_we = wr_acc && wr_in_map;
        if (cast_acc) begin
          div_req.start    = 1'b1;
          div_req.dividend = {1'b1, 32'b0};
          div_req.divisor  = 24'(mag_x);
          mx_d    = MapCoordW'(origin_x_i[22:16]);
          my_d    = MapCoordW'(origin_y_i[22:16]);
          left_d  = 1'b0;
          state_d = S_RECX;
        end
      end
      S_RECX: begin
        if (div_rsp.done) begin
          rec_x_d = div_rsp.quot[32] ? 32'hFFFFFFFF : div_rsp.quot[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = {1'b1, 32'b0};
          div_req.divisor  = 24'(mag_y);
          state_d = S_RECY;
        end
      end
      S_RECY: begin
        if (div_rsp.done) begin
          rec_y_d = div_rsp.quot[32] ? 32'hFFFFFFFF : div_rsp.quot[31:0];
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        state_d = S_MULY;
      end
      S_MULY: begin
        side_x_d = SideW'(mul_q[48:16]);
        state_d  = S_SIDEY;
      end
      S_SIDEY: begin
        side_y_d = SideW'(mul_q[48:16]);
        state_d  = S_STEP;
      end
      S_STEP: begin
        // advance one cell along the nearer grid line; a tie advances in y
        if (x_first) begin
          side_x_d = side_x_q + SideW'(rec_x_q);
          side_d   = 1'b0;
        end else begin
          side_y_d = side_y_q + SideW'(rec_y_q);
          side_d   = 1'b1;
        end
        mx_d = nx;
        my_d = ny;
        if (in_map) begin
          state_d = S_TEST;
        end else begin
          left_d  = 1'b1;
          state_d = S_DIST;
        end
      end
      S_TEST: begin
        state_d = (rd_tile_q != 8'd0) ? S_DIST : S_STEP;
      end
      S_DIST: begin
        div_req.start    = 1'b1;
        div_req.dividend = {5'b0, height_q, 16'b0};
        div_req.divisor  = perp_d;
        state_d = S_LINE;
      end
      S_LINE: begin
        if (div_rsp.done) begin
          line_d  = (|div_rsp.quot[32:16]) ? 16'hFFFF : div_rsp.quot[15:0];
          state_d = S_TEX;
        end
      end
      S_TEX: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result still waits
        if (!out_valid_o || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_x_q  <= rec_x_d;
    rec_y_q  <= rec_y_d;
    side_x_q <= side_x_d;
    side_y_q <= side_y_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    side_q   <= side_d;
    left_q   <= left_d;
    line_q   <= line_d;
    if (cast_acc) begin
      fx_q    <= origin_x_i[15:0];
      fy_q    <= origin_y_i[15:0];
      dir_x_q <= ray_dir_x_i;
      dir_y_q <= ray_dir_y_i;
    end
    if (state_q == S_DIST) begin
      perp_q <= perp_d;
    end
    if (state_q == S_TEX) begin
      tex_q <= tex_d;
    end
    if (load_out) begin
      perp_distance_o <= perp_q;
      hit_side_o      <= side_q;
      hit_x_o         <= left_q ? 7'd0 : mx_q[6:0];
      hit_y_o         <= left_q ? 7'd0 : my_q[6:0];
      left_map_o      <= left_q;
      tex_column_o    <= tex_q;
      line_height_o   <= line_q;
      draw_start_o    <= draw_s;
      draw_end_o      <= draw_e;
    end
  end

`ifndef SYNTHESIS
  a_cast_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cast_acc |=> (state_q == S_RECX))
    else $error("cast transfer did not start the reciprocal division");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_left_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && left_map_o) |-> (hit_x_o == 7'd0 && hit_y_o == 7'd0))
    else $error("left map result carries a nonzero cell");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule
